[sv/hsv_pkg.sv]
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared widths, constants, types and helpers of the hsv to rgb converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int unsigned HUE_W  = 16;
  localparam int unsigned PCT_IN_W = 8;
  localparam int unsigned PCT_W  = 7;   // clamped percent, 0..100
  localparam int unsigned HH_W   = 9;   // folded hue, 0..359
  localparam int unsigned SECT_W = 3;   // sector, 0..5
  localparam int unsigned REM_W  = 6;   // degrees inside a sector, 0..59
  localparam int unsigned TERM_W = 13;  // factor terms, 0..6000
  localparam int unsigned NUM_W  = 20;  // channel numerator over 600000
  localparam int unsigned CH_W   = 13;  // output channel width
  localparam int unsigned NUM_CH = 4;

  localparam int unsigned PCT_MAX   = 100;
  localparam int unsigned DEG_FULL  = 360;
  localparam int unsigned DEG_SECT  = 60;
  localparam int unsigned UNIT_TERM = 6000;  // 100 percent times 60 degrees

  // 2^24 / 360 rounded down, quotient estimate is exact or one low
  localparam int unsigned  HUE_SHIFT = 24;
  localparam logic [15:0]  HUE_RECIP = 16'd46603;

  // channel slots of the numerator bundle
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  typedef struct packed {
    logic             gray;
    logic [PCT_W-1:0] s;
    logic [PCT_W-1:0] v;
    logic [PCT_W-1:0] a;
  } hsv_pct_t;

  typedef struct packed {
    hsv_pct_t          pct;
    logic [SECT_W-1:0] sec;
    logic [REM_W-1:0]  rem;
  } hsv_sect_t;

  typedef logic [NUM_CH-1:0][NUM_W-1:0] hsv_num_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic signed [PCT_IN_W-1:0] x);
    logic [PCT_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > PCT_IN_W'(PCT_MAX)) begin
      res = PCT_W'(PCT_MAX);
    end else begin
      res = PCT_W'(x);
    end
    return res;
  endfunction

endpackage

[sv/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV with alpha to RGB with alpha as rounded fixed-point fractions.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while stall_i is low, set by the ten-stage pipeline
// stalled stages hold; bubbles close up so input is taken while output waits
// reset clears the stage valid bits only, datapath registers are not reset
module hsv_to_rgb_converter import hsv_pkg::*; #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic signed [HUE_W-1:0]    hue_i,
  input  logic signed [PCT_IN_W-1:0] saturation_i,
  input  logic signed [PCT_IN_W-1:0] brightness_i,
  input  logic signed [PCT_IN_W-1:0] opacity_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [CH_W-1:0]            red_o,
  output logic [CH_W-1:0]            green_o,
  output logic [CH_W-1:0]            blue_o,
  output logic [CH_W-1:0]            alpha_out_o
);

  localparam int unsigned NS      = 10;
  localparam int unsigned FIX_ONE = 1 << FRAC_BITS;

  logic [NS-1:0] v_q, v_d, adv;
  hsv_sect_t     sect;
  hsv_num_t      num;
  logic [NUM_CH-1:0][CH_W-1:0] fix;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || !stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_d = ({v_q[NS-2:0], valid_i} & adv) | (v_q & ~adv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !adv[0];
  assign valid_o = v_q[NS-1];

  hsv_hue u_hue (
    .clk_i        (clk_i),
    .en_i         (adv[3:0]),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .opacity_i    (opacity_i),
    .sect_o       (sect)
  );

  hsv_chan u_chan (
    .clk_i  (clk_i),
    .en_i   (adv[5:4]),
    .sect_i (sect),
    .num_o  (num)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_fix
    hsv_fix #(
      .FRAC_BITS (FRAC_BITS)
    ) u_fix (
      .clk_i (clk_i),
      .en_i  (adv[9:6]),
      .num_i (num[c]),
      .fix_o (fix[c])
    );
  end

  assign red_o       = fix[CH_RED];
  assign green_o     = fix[CH_GREEN];
  assign blue_o      = fix[CH_BLUE];
  assign alpha_out_o = fix[CH_ALPHA];

`ifndef SYNTHESIS
  // items in flight change only by what enters and leaves
  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(v_q) == $past($countones(v_q))
      + int'($past(valid_i && !stall_o)) - int'($past(valid_o && !stall_i)))
    else $error("pipeline lost or duplicated an item");

  a_stall_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> v_q[0])
    else $error("input stalled with an empty first stage");

  a_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (sect.sec <= SECT_W'(5)) && (sect.rem < REM_W'(DEG_SECT)))
    else $error("hue fold out of range");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (32'(red_o) <= FIX_ONE) && (32'(green_o) <= FIX_ONE)
      && (32'(blue_o) <= FIX_ONE) && (32'(alpha_out_o) <= FIX_ONE))
    else $error("channel above one");
`endif

endmodule

[sv/hsv_hue.sv]
// ----------------------------------------------------------------------------
// hsv_hue
// Clamps the percent inputs and folds the hue into a sector and an offset.
// ----------------------------------------------------------------------------
module hsv_hue import hsv_pkg::*; (
  input  logic                       clk_i,
  input  logic [3:0]                 en_i,
  input  logic signed [HUE_W-1:0]    hue_i,
  input  logic signed [PCT_IN_W-1:0] saturation_i,
  input  logic signed [PCT_IN_W-1:0] brightness_i,
  input  logic signed [PCT_IN_W-1:0] opacity_i,
  output hsv_sect_t                  sect_o
);

  logic [HUE_W-1:0]    habs_d, habs_q, habs2_q;
  hsv_pct_t            pct_d, pct1_q, pct2_q, pct3_q;
  logic [31:0]         prod_q;
  logic [7:0]          quot;
  logic [HUE_W:0]      diff;
  logic [HH_W-1:0]     hh_d, hh_q;
  hsv_sect_t           sect_d, sect_q;

  // stage 1: magnitude of the hue, clamped percents
  always_comb begin
    habs_d     = hue_i[HUE_W-1] ? (~HUE_W'(hue_i) + HUE_W'(1)) : HUE_W'(hue_i);
    pct_d.gray = saturation_i[PCT_IN_W-1] || (saturation_i == '0);
    pct_d.s    = clamp_pct(saturation_i);
    pct_d.v    = clamp_pct(brightness_i);
    pct_d.a    = clamp_pct(opacity_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      habs_q <= habs_d;
      pct1_q <= pct_d;
    end
  end

  // stage 2: reciprocal multiply for the quotient by 360
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q  <= 32'(habs_q) * 32'(HUE_RECIP);
      habs2_q <= habs_q;
      pct2_q  <= pct1_q;
    end
  end

  // stage 3: remainder with one correction step
  always_comb begin
    quot = prod_q[HUE_SHIFT+7:HUE_SHIFT];
    diff = (HUE_W+1)'(habs2_q) - (HUE_W+1)'(quot) * (HUE_W+1)'(DEG_FULL);
    if (diff >= (HUE_W+1)'(DEG_FULL)) begin
      hh_d = HH_W'(diff - (HUE_W+1)'(DEG_FULL));
    end else begin
      hh_d = HH_W'(diff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hh_q   <= hh_d;
      pct3_q <= pct2_q;
    end
  end

  // stage 4: sector and offset inside the sector
  always_comb begin
    sect_d.pct = pct3_q;
    priority if (hh_q >= HH_W'(5 * DEG_SECT)) begin
      sect_d.sec = SECT_W'(5);
      sect_d.rem = REM_W'(hh_q - HH_W'(5 * DEG_SECT));
    end else if (hh_q >= HH_W'(4 * DEG_SECT)) begin
      sect_d.sec = SECT_W'(4);
      sect_d.rem = REM_W'(hh_q - HH_W'(4 * DEG_SECT));
    end else if (hh_q >= HH_W'(3 * DEG_SECT)) begin
      sect_d.sec = SECT_W'(3);
      sect_d.rem = REM_W'(hh_q - HH_W'(3 * DEG_SECT));
    end else if (hh_q >= HH_W'(2 * DEG_SECT)) begin
      sect_d.sec = SECT_W'(2);
      sect_d.rem = REM_W'(hh_q - HH_W'(2 * DEG_SECT));
    end else if (hh_q >= HH_W'(DEG_SECT)) begin
      sect_d.sec = SECT_W'(1);
      sect_d.rem = REM_W'(hh_q - HH_W'(DEG_SECT));
    end else begin
      sect_d.sec = SECT_W'(0);
      sect_d.rem = REM_W'(hh_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      sect_q <= sect_d;
    end
  end

  assign sect_o = sect_q;

endmodule

[sv/hsv_chan.sv]
// ----------------------------------------------------------------------------
// hsv_chan
// Forms the p, q and t terms and routes them to the channels by sector.
// ----------------------------------------------------------------------------
module hsv_chan import hsv_pkg::*; (
  input  logic       clk_i,
  input  logic [1:0] en_i,
  input  hsv_sect_t  sect_i,
  output hsv_num_t   num_o
);

  logic [TERM_W-1:0] qf_d, tf_d, pf_d, qf_q, tf_q, pf_q;
  logic [SECT_W-1:0] sec_q;
  hsv_pct_t          pct_q;
  logic [NUM_W-1:0]  vv, pn, qn, tn, vn, an;
  hsv_num_t          num_d, num_q;

  // stage 5: factors of v, each at most 6000
  always_comb begin
    qf_d = TERM_W'(UNIT_TERM) - TERM_W'(sect_i.pct.s) * TERM_W'(sect_i.rem);
    tf_d = TERM_W'(UNIT_TERM) - TERM_W'(sect_i.pct.s)
           * (TERM_W'(DEG_SECT) - TERM_W'(sect_i.rem));
    pf_d = (TERM_W'(PCT_MAX) - TERM_W'(sect_i.pct.s)) * TERM_W'(DEG_SECT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      qf_q  <= qf_d;
      tf_q  <= tf_d;
      pf_q  <= pf_d;
      sec_q <= sect_i.sec;
      pct_q <= sect_i.pct;
    end
  end

  // stage 6: scale by v and pick per sector
  always_comb begin
    vv = NUM_W'(pct_q.v);
    pn = vv * NUM_W'(pf_q);
    qn = vv * NUM_W'(qf_q);
    tn = vv * NUM_W'(tf_q);
    vn = vv * NUM_W'(UNIT_TERM);
    an = NUM_W'(pct_q.a) * NUM_W'(UNIT_TERM);
    num_d[CH_ALPHA] = an;
    if (pct_q.gray) begin
      num_d[CH_RED]   = vn;
      num_d[CH_GREEN] = vn;
      num_d[CH_BLUE]  = vn;
    end else begin
      unique case (sec_q)
        3'd0: begin
          num_d[CH_RED] = vn; num_d[CH_GREEN] = tn; num_d[CH_BLUE] = pn;
        end
        3'd1: begin
          num_d[CH_RED] = qn; num_d[CH_GREEN] = vn; num_d[CH_BLUE] = pn;
        end
        3'd2: begin
          num_d[CH_RED] = pn; num_d[CH_GREEN] = vn; num_d[CH_BLUE] = tn;
        end
        3'd3: begin
          num_d[CH_RED] = pn; num_d[CH_GREEN] = qn; num_d[CH_BLUE] = vn;
        end
        3'd4: begin
          num_d[CH_RED] = tn; num_d[CH_GREEN] = pn; num_d[CH_BLUE] = vn;
        end
        default: begin
          num_d[CH_RED] = vn; num_d[CH_GREEN] = pn; num_d[CH_BLUE] = qn;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

[sv/hsv_fix.sv]
// ----------------------------------------------------------------------------
// hsv_fix
// Rounds a numerator over 600000 to a fixed-point fraction, four stages.
// ----------------------------------------------------------------------------
module hsv_fix import hsv_pkg::*; #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic             clk_i,
  input  logic [3:0]       en_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [CH_W-1:0]  fix_o
);

  // 600000 = 64 * 9375: drop six bits, then divide by 9375
  localparam int unsigned FIX_PRE  = 6;
  localparam int unsigned FIX_DIV  = 9375;
  localparam int unsigned FIX_HALF = 300000;
  localparam int unsigned SUM_W    = NUM_W + FRAC_BITS;
  localparam int unsigned YW       = SUM_W - FIX_PRE;
  localparam int unsigned MW       = YW - 13;
  localparam int unsigned PW       = YW + MW;
  localparam int unsigned QW       = FRAC_BITS + 1;
  localparam int unsigned QM_W     = QW + 14;
  localparam logic [MW-1:0] FIX_RECIP = MW'((64'd1 << YW) / 64'd9375);

  logic [SUM_W-1:0] sum;
  logic [YW-1:0]    ys_d, ys_a_q, ys_b_q, ys_c_q;
  logic [PW-1:0]    prod_q;
  logic [QW-1:0]    quot, quot_c_q, quot_d;
  logic [QM_W-1:0]  qm_c_q;
  logic [YW-1:0]    rem;
  logic [CH_W-1:0]  fix_q;

  // stage a: scale and add half of the divisor
  always_comb begin
    sum  = {num_i, {FRAC_BITS{1'b0}}} + SUM_W'(FIX_HALF);
    ys_d = sum[SUM_W-1:FIX_PRE];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ys_a_q <= ys_d;
    end
  end

  // stage b: reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= PW'(ys_a_q) * PW'(FIX_RECIP);
      ys_b_q <= ys_a_q;
    end
  end

  // stage c: back-multiply the estimate, which is exact or one low
  assign quot = prod_q[YW+QW-1:YW];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      qm_c_q   <= QM_W'(quot) * QM_W'(FIX_DIV);
      quot_c_q <= quot;
      ys_c_q   <= ys_b_q;
    end
  end

  // stage d: correction, result wraps to the output width
  always_comb begin
    rem = ys_c_q - YW'(qm_c_q);
    if (rem >= YW'(FIX_DIV)) begin
      quot_d = quot_c_q + QW'(1);
    end else begin
      quot_d = quot_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      fix_q <= CH_W'(quot_d);
    end
  end

  assign fix_o = fix_q;

endmodule
